// ===== hdl/ata_pkg.sv =====
// ----------------------------------------------------------------------------
// ata_pkg
// Shared types and constants of the ASERT target adjustment pipeline.
// ----------------------------------------------------------------------------
package ata_pkg;

  // Target width and register map
  localparam int TgtW    = 224;
  localparam int AddrW   = 6;
  localparam int DataW   = 64;

  localparam logic [2:0] RegSpacing  = 3'd0;
  localparam logic [2:0] RegHalfLife = 3'd1;
  localparam logic [2:0] RegLimitW0  = 3'd2;
  localparam logic [2:0] RegLimitW1  = 3'd3;
  localparam logic [2:0] RegLimitW2  = 3'd4;
  localparam logic [2:0] RegLimitW3  = 3'd5;

  // Divider geometry: quotient bits per stage and stage count
  localparam int DivW      = 64;
  localparam int DivRadix  = 4;
  localparam int DivStages = DivW / DivRadix;

  // Cubic approximation of 2^frac
  localparam logic [63:0] PolyC1   = 64'd195766423245049;
  localparam logic [63:0] PolyC2   = 64'd971821376;
  localparam logic [63:0] PolyC3   = 64'd5127;
  localparam logic [63:0] PolyHalf = 64'd140737488355328;

  // Item data carried alongside the divider
  typedef struct packed {
    logic [TgtW-1:0] tgt;
    logic            neg;
    logic            err;
  } side_t;

endpackage

// ===== hdl/ata_div.sv =====
// ----------------------------------------------------------------------------
// ata_div
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, four
// quotient bits per stage, with item data carried along.
// ----------------------------------------------------------------------------
module ata_div import ata_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [DivW-1:0] in_dvd_i,
  input  logic [31:0]     in_dvs_i,
  input  side_t           in_side_i,
  output logic            out_valid_o,
  output logic [DivW-1:0] out_quo_o,
  output side_t           out_side_o
);

  typedef struct packed {
    logic [31:0]     rem;
    logic [DivW-1:0] dq;
  } div_st_t;

  // Shift dividend bits into the remainder, quotient bits into the bottom
  function automatic div_st_t div_step(div_st_t s, logic [31:0] dvs);
    logic [32:0] r;
    div_st_t     o;
    o = s;
    for (int k = 0; k < DivRadix; k++) begin
      r    = {o.rem, o.dq[DivW-1]};
      o.dq = {o.dq[DivW-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r       = r - {1'b0, dvs};
        o.dq[0] = 1'b1;
      end
      o.rem = r[31:0];
    end
    return o;
  endfunction

  logic    valid_q [DivStages];
  div_st_t st_q    [DivStages];
  side_t   side_q  [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    div_st_t st_in;
    div_st_t st_d;
    logic    v_in;
    side_t   side_in;

    if (g == 0) begin : g_first
      assign st_in   = '{rem: 32'd0, dq: in_dvd_i};
      assign v_in    = in_valid_i;
      assign side_in = in_side_i;
    end else begin : g_next
      assign st_in   = st_q[g-1];
      assign v_in    = valid_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign st_d = div_step(st_in, in_dvs_i);

    // Advance valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else begin
        valid_q[g] <= v_in;
      end
    end

    // Advance partial state and item data
    always_ff @(posedge clk_i) begin
      st_q[g]   <= st_d;
      side_q[g] <= side_in;
    end
  end

  assign out_valid_o = valid_q[DivStages-1];
  assign out_quo_o   = st_q[DivStages-1].dq;
  assign out_side_o  = side_q[DivStages-1];

  // The first stage's remainder stays below the divisor
  a_div_rem_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> (st_q[0].rem < in_dvs_i))
    else $error("divider remainder not below divisor");

  a_div_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> ##(DivStages) out_valid_o)
    else $error("divider lost an item");

  a_div_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> $past(valid_q[0]))
    else $error("divider invented an item");

endmodule

// ===== hdl/asert_target_adjust.sv =====
// ----------------------------------------------------------------------------
// asert_target_adjust
// ASERT target adjustment: 48.16 exponent by pipelined division, cubic
// 2^frac factor, 224-bit multiply, signed shift and limiting.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy stays low, every stage advances
//   each cycle and the divider's 16 stages set most of the depth.
// Reset: clears valid bits and the output strobe, loads register defaults
//   (spacing 600, half life 172800, limit all ones).
module asert_target_adjust import ata_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // command
  input  logic              start,
  output logic              busy,
  input  logic [63:0]       ref_target_w0_i,
  input  logic [63:0]       ref_target_w1_i,
  input  logic [63:0]       ref_target_w2_i,
  input  logic [31:0]       ref_target_w3_i,
  input  logic signed [47:0] time_diff_i,
  input  logic [31:0]       height_diff_i,
  // result
  output logic              done_o,
  output logic [63:0]       next_target_w0_o,
  output logic [63:0]       next_target_w1_o,
  output logic [63:0]       next_target_w2_o,
  output logic [31:0]       next_target_w3_o,
  output logic              clamped_o,
  output logic              input_error_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]     spacing_q;
  logic [31:0]     half_life_q;
  logic [63:0]     lim_w0_q, lim_w1_q, lim_w2_q;
  logic [31:0]     lim_w3_q;
  logic [TgtW-1:0] lim;
  logic [31:0]     hl_eff;
  logic            wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite;
  assign lim    = {lim_w3_q, lim_w2_q, lim_w1_q, lim_w0_q};
  assign hl_eff = (half_life_q == 32'd0) ? 32'd1 : half_life_q;

  // Take a write transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= 16'd600;
      half_life_q <= 32'd172800;
      lim_w0_q    <= '1;
      lim_w1_q    <= '1;
      lim_w2_q    <= '1;
      lim_w3_q    <= '1;
    end else if (wr_en) begin
      case (paddr[5:3])
        RegSpacing:  spacing_q   <= pwdata[15:0];
        RegHalfLife: half_life_q <= pwdata[31:0];
        RegLimitW0:  lim_w0_q    <= pwdata;
        RegLimitW1:  lim_w1_q    <= pwdata;
        RegLimitW2:  lim_w2_q    <= pwdata;
        RegLimitW3:  lim_w3_q    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Return register contents
  always_comb begin
    case (paddr[5:3])
      RegSpacing:  prdata = {48'd0, spacing_q};
      RegHalfLife: prdata = {32'd0, half_life_q};
      RegLimitW0:  prdata = lim_w0_q;
      RegLimitW1:  prdata = lim_w1_q;
      RegLimitW2:  prdata = lim_w2_q;
      RegLimitW3:  prdata = {32'd0, lim_w3_q};
      default:     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Valid chain
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v10_q, v11_q, v12_q, v13_q, done_q;
  logic div_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
      {v10_q, v11_q, v12_q, v13_q, done_q}                  <= '0;
    end else begin
      v1_q   <= start & ~busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= div_v;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= v7_q;
      v9_q   <= v8_q;
      v10_q  <= v9_q;
      v11_q  <= v10_q;
      v12_q  <= v11_q;
      v13_q  <= v12_q;
      done_q <= v13_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: spacing * height, target checks
  // --------------------------------------------------------------------------
  logic [TgtW-1:0]   tgt_in;
  logic [TgtW-1:0]   s1_tgt_q, s2_tgt_q, s3_tgt_q, s4_tgt_q;
  logic signed [47:0] s1_tdiff_q;
  logic [47:0]       s1_prod_q;
  logic              s1_err_q, s2_err_q, s3_err_q, s4_err_q;

  assign tgt_in = {ref_target_w3_i, ref_target_w2_i, ref_target_w1_i, ref_target_w0_i};

  always_ff @(posedge clk_i) begin
    s1_tgt_q   <= tgt_in;
    s1_tdiff_q <= time_diff_i;
    s1_prod_q  <= spacing_q * height_diff_i;
    s1_err_q   <= (tgt_in == '0) || (tgt_in > lim);
  end

  // Stage 2: drift d = time - spacing*height
  logic signed [49:0] s2_d_q;

  always_ff @(posedge clk_i) begin
    s2_tgt_q <= s1_tgt_q;
    s2_err_q <= s1_err_q;
    s2_d_q   <= $signed({{2{s1_tdiff_q[47]}}, s1_tdiff_q}) - $signed({2'b00, s1_prod_q});
  end

  // Stage 3: range check on d, n = d - spacing
  logic signed [49:0] s3_n_q;
  logic               d_big;

  assign d_big = (s2_d_q >= $signed(50'h0_8000_0000_0000))
              || (s2_d_q <= -$signed(50'h0_8000_0000_0000));

  always_ff @(posedge clk_i) begin
    s3_tgt_q <= s2_tgt_q;
    s3_err_q <= s2_err_q | d_big;
    s3_n_q   <= s2_d_q - $signed({34'd0, spacing_q});
  end

  // Stage 4: sign and magnitude of n
  logic        s4_neg_q;
  logic [47:0] s4_mag_q;
  logic [49:0] n_abs;

  assign n_abs = s3_n_q[49] ? 50'(-s3_n_q) : 50'(s3_n_q);

  always_ff @(posedge clk_i) begin
    s4_tgt_q <= s3_tgt_q;
    s4_err_q <= s3_err_q;
    s4_neg_q <= s3_n_q[49];
    s4_mag_q <= n_abs[47:0];
  end

  // --------------------------------------------------------------------------
  // Divider: q = (mag << 16) / half_life
  // --------------------------------------------------------------------------
  side_t           div_side_in, div_side;
  logic [DivW-1:0] div_q;

  assign div_side_in = '{tgt: s4_tgt_q, neg: s4_neg_q, err: s4_err_q};

  ata_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_dvd_i    ({s4_mag_q, 16'd0}),
    .in_dvs_i    (hl_eff),
    .in_side_i   (div_side_in),
    .out_valid_o (div_v),
    .out_quo_o   (div_q),
    .out_side_o  (div_side)
  );

  // --------------------------------------------------------------------------
  // Stage 5: floor split into shift amount and fraction
  // --------------------------------------------------------------------------
  logic signed [50:0] sh_pos, sh_all, sh_m16;
  logic [50:0]        amt_full;
  logic [15:0]        low;
  logic [TgtW-1:0]    s5_tgt_q, s6_tgt_q, s7_tgt_q, s8_tgt_q, s9_tgt_q;
  logic               s5_err_q, s6_err_q, s7_err_q, s8_err_q, s9_err_q;
  logic               s5_big_q, s6_big_q, s7_big_q, s8_big_q, s9_big_q;
  logic               s5_tiny_q, s6_tiny_q, s7_tiny_q, s8_tiny_q, s9_tiny_q;
  logic [8:0]         s5_amt_q, s6_amt_q, s7_amt_q, s8_amt_q, s9_amt_q;
  logic [15:0]        s5_frac_q;

  assign low      = div_q[15:0];
  assign sh_pos   = $signed({3'd0, div_q[63:16]});
  assign sh_all   = !div_side.neg ? sh_pos
                  : (-sh_pos - $signed({50'd0, (low != 16'd0)}));
  assign sh_m16   = sh_all - 51'sd16;
  assign amt_full = 51'(sh_m16 + 51'sd256);

  always_ff @(posedge clk_i) begin
    s5_tgt_q  <= div_side.tgt;
    s5_err_q  <= div_side.err;
    s5_big_q  <= sh_m16 > 51'sd240;
    s5_tiny_q <= sh_m16 < -51'sd256;
    s5_amt_q  <= amt_full[8:0];
    s5_frac_q <= div_side.neg ? 16'(-low) : low;
  end

  // --------------------------------------------------------------------------
  // Stages 6 to 9: factor = 65536 + poly(frac) >> 48
  // --------------------------------------------------------------------------
  logic [15:0] s6_f_q;
  logic [31:0] s6_f2_q;
  logic [63:0] s6_t1_q, s7_t1_q, s7_t2_q, s8_sum_q, s8_t3_q;
  logic [47:0] s7_f3_q;
  logic [63:0] poly_sum;
  logic [16:0] s9_factor_q;

  assign poly_sum = s8_sum_q + s8_t3_q + PolyHalf;

  always_ff @(posedge clk_i) begin
    // powers of frac and first term
    s6_f_q      <= s5_frac_q;
    s6_f2_q     <= s5_frac_q * s5_frac_q;
    s6_t1_q     <= PolyC1 * {48'd0, s5_frac_q};
    // cube and second term
    s7_f3_q     <= s6_f2_q * s6_f_q;
    s7_t2_q     <= PolyC2 * {32'd0, s6_f2_q};
    s7_t1_q     <= s6_t1_q;
    // third term, running sum
    s8_t3_q     <= PolyC3 * {16'd0, s7_f3_q};
    s8_sum_q    <= s7_t1_q + s7_t2_q;
    // round and offset
    s9_factor_q <= {1'b1, poly_sum[63:48]};
  end

  // Carry item data along the polynomial stages
  always_ff @(posedge clk_i) begin
    s6_tgt_q <= s5_tgt_q;  s6_err_q <= s5_err_q;  s6_big_q <= s5_big_q;
    s6_tiny_q <= s5_tiny_q; s6_amt_q <= s5_amt_q;
    s7_tgt_q <= s6_tgt_q;  s7_err_q <= s6_err_q;  s7_big_q <= s6_big_q;
    s7_tiny_q <= s6_tiny_q; s7_amt_q <= s6_amt_q;
    s8_tgt_q <= s7_tgt_q;  s8_err_q <= s7_err_q;  s8_big_q <= s7_big_q;
    s8_tiny_q <= s7_tiny_q; s8_amt_q <= s7_amt_q;
    s9_tgt_q <= s8_tgt_q;  s9_err_q <= s8_err_q;  s9_big_q <= s8_big_q;
    s9_tiny_q <= s8_tiny_q; s9_amt_q <= s8_amt_q;
  end

  // --------------------------------------------------------------------------
  // Stages 10 and 11: target * factor as seven 32x17 lanes, then one add
  // --------------------------------------------------------------------------
  logic [48:0]  s10_pp_q [7];
  logic         s10_err_q, s11_err_q, s12_err_q, s13_err_q;
  logic         s10_big_q, s11_big_q, s12_big_q;
  logic         s10_tiny_q, s11_tiny_q, s12_tiny_q;
  logic [8:0]   s10_amt_q, s11_amt_q, s12_amt_q;
  logic [255:0] pp_even, pp_odd;
  logic [255:0] s11_p_q;

  for (genvar l = 0; l < 7; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      s10_pp_q[l] <= s9_tgt_q[32*l +: 32] * s9_factor_q;
    end
  end

  assign pp_even = {15'd0, s10_pp_q[6], 15'd0, s10_pp_q[4],
                    15'd0, s10_pp_q[2], 15'd0, s10_pp_q[0]};
  assign pp_odd  = {47'd0, s10_pp_q[5], 15'd0, s10_pp_q[3],
                    15'd0, s10_pp_q[1], 32'd0};

  always_ff @(posedge clk_i) begin
    s10_err_q <= s9_err_q;  s10_big_q <= s9_big_q;
    s10_tiny_q <= s9_tiny_q; s10_amt_q <= s9_amt_q;
    s11_p_q   <= pp_even + pp_odd;
    s11_err_q <= s10_err_q; s11_big_q <= s10_big_q;
    s11_tiny_q <= s10_tiny_q; s11_amt_q <= s10_amt_q;
  end

  // --------------------------------------------------------------------------
  // Stages 12 and 13: shift by (amt - 256), coarse then fine
  // --------------------------------------------------------------------------
  logic [751:0]    s12_x_q;
  logic [751:0]    shf_y;
  logic [TgtW-1:0] s13_val_q;
  logic            s13_ovf_q, s13_zero_q;

  assign shf_y = s12_x_q << s12_amt_q[3:0];

  // A long right shift leaves a meaningless amount: ignore its overflow bits
  always_ff @(posedge clk_i) begin
    s12_x_q    <= {496'd0, s11_p_q} << {s11_amt_q[8:4], 4'd0};
    s12_err_q  <= s11_err_q; s12_big_q <= s11_big_q;
    s12_tiny_q <= s11_tiny_q; s12_amt_q <= s11_amt_q;
    s13_err_q  <= s12_err_q;
    s13_ovf_q  <= s12_big_q | (~s12_tiny_q & (|shf_y[751:480]));
    s13_val_q  <= shf_y[479:256];
    s13_zero_q <= s12_tiny_q | (shf_y[479:256] == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 14: limit and raise, drive the result
  // --------------------------------------------------------------------------
  logic [TgtW-1:0] res_d, res_q;
  logic            clamp_d, clamp_q, err_q;

  always_comb begin
    res_d   = s13_val_q;
    clamp_d = 1'b0;
    if (s13_err_q) begin
      res_d = lim;
    end else if (s13_ovf_q) begin
      res_d   = lim;
      clamp_d = 1'b1;
    end else if (s13_zero_q) begin
      res_d   = {{(TgtW-1){1'b0}}, 1'b1};
      clamp_d = 1'b1;
    end else if (s13_val_q > lim) begin
      res_d   = lim;
      clamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    clamp_q <= clamp_d;
    err_q   <= s13_err_q;
  end

  assign done_o           = done_q;
  assign next_target_w0_o = res_q[63:0];
  assign next_target_w1_o = res_q[127:64];
  assign next_target_w2_o = res_q[191:128];
  assign next_target_w3_o = res_q[223:192];
  assign clamped_o        = clamp_q;
  assign input_error_o    = err_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##30 done_o)
    else $error("result missing 30 cycles after start transfer");

  a_err_not_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(clamped_o && input_error_o))
    else $error("error and clamp flags both set");

  a_err_gives_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && input_error_o) |-> (res_q == lim))
    else $error("input error result is not the limit");

  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !input_error_o) |-> (res_q != '0))
    else $error("zero target delivered");

endmodule
